// ===== rtl/uh61_pkg.sv =====
// ----------------------------------------------------------------------------
// uh61_pkg
// shared constants and modular helpers for the mersenne-61 universal hash
// ----------------------------------------------------------------------------
`default_nettype none

package uh61_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned RES_W   = 61;

    localparam logic [RES_W-1:0] P61 = {RES_W{1'b1}};
    localparam logic [RES_W-1:0] PM1 = P61 - 61'd1;

    typedef enum logic [IDX_W-1:0] {
        REG_MULT_SEED    = 8'd0,
        REG_OFFSET_SEED  = 8'd1,
        REG_BUCKET_COUNT = 8'd2
    } cfg_index_t;

    typedef logic [RES_W-1:0] res_t;

    // fold a value below 2^63 into [0, p)
    function automatic res_t fold61(input logic [62:0] v);
        logic [61:0] s;
        s = {1'b0, v[60:0]} + {60'd0, v[62:61]};
        if (s >= {1'b0, P61})
            s = s - {1'b0, P61};
        return s[RES_W-1:0];
    endfunction

    // 64-bit value mod p
    function automatic res_t mod_p(input logic [CFG_W-1:0] v);
        logic [61:0] s;
        s = {1'b0, v[60:0]} + {59'd0, v[63:61]};
        if (s >= {1'b0, P61})
            s = s - {1'b0, P61};
        return s[RES_W-1:0];
    endfunction

    // (64-bit value mod (p-1)) + 1, using 2^61 == 2 mod (p-1)
    function automatic res_t mult_from_seed(input logic [CFG_W-1:0] v);
        logic [61:0] s;
        s = {1'b0, v[60:0]} + {58'd0, v[63:61], 1'b0};
        if (s >= {1'b0, PM1})
            s = s - {1'b0, PM1};
        return s[RES_W-1:0] + 61'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uh61_ifs.sv =====
// ----------------------------------------------------------------------------
// uh61 interfaces
// key, bucket and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface uh61_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] key;
    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface uh61_bucket_if;
    logic        valid;
    logic        ready;
    logic [60:0] bucket;
    modport source (output valid, output bucket, input ready);
    modport sink   (input valid, input bucket, output ready);
endinterface

interface uh61_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/uh61_cfg.sv =====
// ----------------------------------------------------------------------------
// uh61_cfg
// configuration registers, stores derived multiplier, offset and divisor
// ----------------------------------------------------------------------------
`default_nettype none

module uh61_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [uh61_pkg::IDX_W-1:0] wr_index,
    input  wire logic [uh61_pkg::CFG_W-1:0] wr_data,
    output uh61_pkg::res_t                 mult,
    output uh61_pkg::res_t                 offset,
    output logic [uh61_pkg::CFG_W-1:0]     divisor
);
    import uh61_pkg::*;

    res_t             mult_reg,   mult_next;
    res_t             offset_reg, offset_next;
    logic [CFG_W-1:0] div_reg,    div_next;

    always_comb
    begin
        mult_next   = mult_reg;
        offset_next = offset_reg;
        div_next    = div_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MULT_SEED:    mult_next   = mult_from_seed(wr_data);
                REG_OFFSET_SEED:  offset_next = mod_p(wr_data);
                // zero buckets behaves like one bucket
                REG_BUCKET_COUNT: div_next    = (wr_data == '0) ? 64'd1 : wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg   <= 61'd1;
            offset_reg <= '0;
            div_reg    <= 64'd1;
        end
        else
        begin
            mult_reg   <= mult_next;
            offset_reg <= offset_next;
            div_reg    <= div_next;
        end
    end

    assign mult    = mult_reg;
    assign offset  = offset_reg;
    assign divisor = div_reg;

endmodule

`default_nettype wire

// ===== rtl/uh61_mulmod.sv =====
// ----------------------------------------------------------------------------
// uh61_mulmod
// six-stage pipeline computing (a*x + b) mod p from 32-bit partial products
// ----------------------------------------------------------------------------
`default_nettype none

module uh61_mulmod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [uh61_pkg::KEY_W-1:0] key,
    input  wire uh61_pkg::res_t             mult,
    input  wire uh61_pkg::res_t             offset,
    output logic                            out_valid,
    output uh61_pkg::res_t                  hash
);
    import uh61_pkg::*;

    localparam int unsigned NST = 6;

    logic [NST-1:0] v_reg;
    res_t           x_reg;
    logic [63:0]    p00_reg;
    logic [60:0]    p01_reg;
    logic [60:0]    p10_reg;
    logic [57:0]    p11_reg;
    logic [121:0]   prod_reg, prod_next;
    logic [61:0]    t_reg, t_next;
    res_t           h1_reg;
    res_t           h_reg;

    always_comb
    begin
        prod_next = {58'd0, p00_reg}
                  + ({61'd0, p01_reg} << 32)
                  + ({61'd0, p10_reg} << 32)
                  + ({64'd0, p11_reg} << 64);
        t_next    = {1'b0, prod_reg[121:61]} + {1'b0, prod_reg[60:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= key[RES_W-1:0];
            p00_reg  <= {32'd0, mult[31:0]} * {32'd0, x_reg[31:0]};
            p01_reg  <= {29'd0, mult[31:0]} * {32'd0, x_reg[60:32]};
            p10_reg  <= {32'd0, mult[60:32]} * {29'd0, x_reg[31:0]};
            p11_reg  <= {29'd0, mult[60:32]} * {29'd0, x_reg[60:32]};
            prod_reg <= prod_next;
            t_reg    <= t_next;
            h1_reg   <= fold61({1'b0, t_reg});
            h_reg    <= fold61({2'b0, h1_reg} + {2'b0, offset});
        end
    end

    assign out_valid = v_reg[NST-1];
    assign hash      = h_reg;

endmodule

`default_nettype wire

// ===== rtl/uh61_divider.sv =====
// ----------------------------------------------------------------------------
// uh61_divider
// pipelined restoring remainder, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module uh61_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire uh61_pkg::res_t             dividend,
    input  wire logic [uh61_pkg::CFG_W-1:0] divisor,
    output logic                            out_valid,
    output uh61_pkg::res_t                  remainder
);
    import uh61_pkg::*;

    localparam int unsigned NST = RES_W;

    logic [NST-1:0] v_reg;
    res_t           rem_reg [NST];
    res_t           num_reg [NST-1];
    res_t           rem_next[NST];

    always_comb
    begin
        logic [CFG_W-1:0] sh;
        // first stage takes the top dividend bit straight from the input
        sh = {{(CFG_W-1){1'b0}}, dividend[RES_W-1]};
        if (sh >= divisor)
            sh = sh - divisor;
        rem_next[0] = sh[RES_W-1:0];
        for (int k = 1; k < NST; k++)
        begin
            sh = {2'b0, rem_reg[k-1], num_reg[k-1][RES_W-1-k]};
            if (sh >= divisor)
                sh = sh - divisor;
            rem_next[k] = sh[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
                rem_reg[k] <= rem_next[k];
            num_reg[0] <= dividend;
            for (int k = 1; k < NST - 1; k++)
                num_reg[k] <= num_reg[k-1];
        end
    end

    assign out_valid = v_reg[NST-1];
    assign remainder = rem_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/universal_hash_mersenne61.sv =====
// ----------------------------------------------------------------------------
// universal_hash_mersenne61
// carter-wegman hash ((a*x + b) mod (2^61-1)) mod bucket_count
// ----------------------------------------------------------------------------
// pipeline: 6 mulmod stages then 61 divider stages from key request to bucket request
// throughput: one key per cycle while no waiting result stalls the fully pipelined remainder stages
// the whole pipeline advances together; it holds when a result waits unserved
// reset: pipeline empties, multiplier = 1, offset = 0, bucket count = 1
// ----------------------------------------------------------------------------
`default_nettype none

module universal_hash_mersenne61 (
    input  wire logic     clk,
    input  wire logic     rst_n,
    uh61_key_if.sink      keys,
    uh61_bucket_if.source buckets,
    uh61_cfg_if.sink      cfg
);
    import uh61_pkg::*;

    res_t             mult;
    res_t             offset;
    logic [CFG_W-1:0] divisor;
    logic             en;
    logic             mm_valid;
    res_t             mm_hash;
    logic             div_valid;
    res_t             div_rem;

    // configuration is always taken; writes must happen only while idle, which the block does not enforce
    assign cfg.ready = 1'b1;

    uh61_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .mult     (mult),
        .offset   (offset),
        .divisor  (divisor)
    );

    // pipeline moves when the output slot is empty or being drained
    assign en         = !div_valid || buckets.ready;
    assign keys.ready = en;

    // mod-p front end: partial products, sum, hi+lo fold, two fold61 reductions, offset add
    uh61_mulmod u_mulmod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (keys.valid),
        .key       (keys.key),
        .mult      (mult),
        .offset    (offset),
        .out_valid (mm_valid),
        .hash      (mm_hash)
    );

    // remainder by bucket count, last stage doubles as the output register
    uh61_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mm_valid),
        .dividend  (mm_hash),
        .divisor   (divisor),
        .out_valid (div_valid),
        .remainder (div_rem)
    );

    assign buckets.valid  = div_valid;
    assign buckets.bucket = div_rem;

    // bucket always below the bucket count
    assert property (@(posedge clk) disable iff (!rst_n)
        buckets.valid |-> ({3'd0, buckets.bucket} < divisor))
    else $error("bucket not below bucket count");

    // bucket always a reduced residue
    assert property (@(posedge clk) disable iff (!rst_n)
        buckets.valid |-> (buckets.bucket != P61))
    else $error("bucket equals p");

    // derived multiplier stays in [1, p-1]
    assert property (@(posedge clk) disable iff (!rst_n)
        (mult != '0) && (mult != P61))
    else $error("multiplier out of range");

endmodule

`default_nettype wire
